// ===== design/base_fee_adjust_core_macros.svh =====
// Assertion macros for the base fee adjust checker
`ifndef BASE_FEE_ADJUST_CORE_MACROS_SVH
`define BASE_FEE_ADJUST_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bfa_pkg.sv =====
// Types and constants shared by the base fee adjust design
package bfa_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int HALF_WIDTH  = VALUE_WIDTH / 2;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int DIV_STAGES  = PROD_WIDTH;
    localparam int CHANGE_SHIFT = 3;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] base_fee;
        logic [VALUE_WIDTH-1:0] gas_used;
        logic [VALUE_WIDTH-1:0] gas_limit;
    } item_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] next_fee;
        logic                   saturated;
        logic                   zero_target;
    } result_t;

    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_ZT,
        KIND_UP,
        KIND_DOWN
    } kind_t;

endpackage

// ===== design/base_fee_adjust_core.sv =====
// Base fee adjust core: pipelined multiply, bit-per-stage divide, final adjust
// Pipeline: 1 classify, 2 multiply, 128 divide stages of one quotient bit each,
// and 1 adjust/output register.
// Throughput: one beat per cycle; the whole pipe halts while the output beat stalls.
// Reset (rst_n low, async): all stage valid bits cleared; no results pending.
module base_fee_adjust_core
    import bfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [VALUE_WIDTH-1:0] MAX_VAL = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] ONE_VAL = VALUE_WIDTH'(1);

    logic adv;

    // classify stage
    logic                   s0_valid_reg;
    logic [VALUE_WIDTH-1:0] s0_fee_reg, s0_delta_reg, s0_tgt_reg;
    kind_t                  s0_kind_reg;
    logic [VALUE_WIDTH-1:0] target, delta_next;
    kind_t                  kind_next;

    // partial products
    logic                   s1_valid_reg;
    logic [VALUE_WIDTH-1:0] s1_fee_reg, s1_tgt_reg;
    kind_t                  s1_kind_reg;
    logic [VALUE_WIDTH-1:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // divider stage array; index 0 is the product stage
    logic                   dv_valid_reg [0:DIV_STAGES];
    logic [PROD_WIDTH-1:0]  dv_n_reg     [0:DIV_STAGES];
    logic [VALUE_WIDTH-1:0] dv_r_reg     [0:DIV_STAGES];
    logic [VALUE_WIDTH-1:0] dv_fee_reg   [0:DIV_STAGES];
    logic [VALUE_WIDTH-1:0] dv_tgt_reg   [0:DIV_STAGES];
    kind_t                  dv_kind_reg  [0:DIV_STAGES];
    logic [PROD_WIDTH-1:0]  prod_next;

    logic    out_valid_reg;
    result_t out_reg, out_next;

    assign adv          = !out_valid_reg || !result_stall;
    assign item_stall   = !adv;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        target     = item.gas_limit >> 1;
        delta_next = '0;
        if (item.gas_used == target)
        begin
            kind_next = KIND_HOLD;
        end
        else if (target == '0)
        begin
            kind_next = KIND_ZT;
        end
        else if (item.gas_used > target)
        begin
            kind_next  = KIND_UP;
            delta_next = item.gas_used - target;
        end
        else
        begin
            kind_next  = KIND_DOWN;
            delta_next = target - item.gas_used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= item_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_fee_reg   <= item.base_fee;
            s0_delta_reg <= delta_next;
            s0_tgt_reg   <= target;
            s0_kind_reg  <= kind_next;
            s1_fee_reg   <= s0_fee_reg;
            s1_tgt_reg   <= s0_tgt_reg;
            s1_kind_reg  <= s0_kind_reg;
            p00_reg <= s0_fee_reg[HALF_WIDTH-1:0] * s0_delta_reg[HALF_WIDTH-1:0];
            p01_reg <= s0_fee_reg[HALF_WIDTH-1:0] * s0_delta_reg[VALUE_WIDTH-1:HALF_WIDTH];
            p10_reg <= s0_fee_reg[VALUE_WIDTH-1:HALF_WIDTH] * s0_delta_reg[HALF_WIDTH-1:0];
            p11_reg <= s0_fee_reg[VALUE_WIDTH-1:HALF_WIDTH]
                     * s0_delta_reg[VALUE_WIDTH-1:HALF_WIDTH];
        end
    end

    assign prod_next = PROD_WIDTH'(p00_reg)
                     + (PROD_WIDTH'(p01_reg) << HALF_WIDTH)
                     + (PROD_WIDTH'(p10_reg) << HALF_WIDTH)
                     + (PROD_WIDTH'(p11_reg) << VALUE_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_n_reg[0]    <= prod_next;
            dv_r_reg[0]    <= '0;
            dv_fee_reg[0]  <= s1_fee_reg;
            dv_tgt_reg[0]  <= s1_tgt_reg;
            dv_kind_reg[0] <= s1_kind_reg;
        end
    end

    // one restoring-division bit per stage; quotient shifts into n
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [VALUE_WIDTH:0] shifted, diff;
        logic                 ge;

        assign shifted = {dv_r_reg[k], dv_n_reg[k][PROD_WIDTH-1]};
        assign diff    = shifted - {1'b0, dv_tgt_reg[k]};
        assign ge      = (shifted >= {1'b0, dv_tgt_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_n_reg[k+1]    <= {dv_n_reg[k][PROD_WIDTH-2:0], ge};
                dv_r_reg[k+1]    <= ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
                dv_fee_reg[k+1]  <= dv_fee_reg[k];
                dv_tgt_reg[k+1]  <= dv_tgt_reg[k];
                dv_kind_reg[k+1] <= dv_kind_reg[k];
            end
        end
    end

    always_comb
    begin
        logic [PROD_WIDTH-1:0]  q;
        logic                   q_hi_nz;
        logic [VALUE_WIDTH-1:0] q_lo, fee, inc;

        q       = dv_n_reg[DIV_STAGES];
        fee     = dv_fee_reg[DIV_STAGES];
        q_hi_nz = |q[PROD_WIDTH-1:VALUE_WIDTH+CHANGE_SHIFT];
        q_lo    = q[VALUE_WIDTH+CHANGE_SHIFT-1:CHANGE_SHIFT];
        inc     = (!q_hi_nz && q_lo == '0) ? ONE_VAL : q_lo;

        out_next.next_fee    = fee;
        out_next.saturated   = 1'b0;
        out_next.zero_target = 1'b0;
        unique case (dv_kind_reg[DIV_STAGES])
            KIND_HOLD:
            begin
                out_next.next_fee = fee;
            end
            KIND_ZT:
            begin
                out_next.zero_target = 1'b1;
            end
            KIND_UP:
            begin
                if (q_hi_nz || inc > (MAX_VAL - fee))
                begin
                    out_next.next_fee  = MAX_VAL;
                    out_next.saturated = 1'b1;
                end
                else
                begin
                    out_next.next_fee = fee + inc;
                end
            end
            KIND_DOWN:
            begin
                if (q_hi_nz || q_lo >= fee)
                begin
                    out_next.next_fee = ONE_VAL;
                end
                else
                begin
                    out_next.next_fee = fee - q_lo;
                end
            end
            default:
            begin
                out_next.next_fee = fee;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== design/bfa_checker.sv =====
// Port-level checker for base_fee_adjust_core and its bind
`include "base_fee_adjust_core_macros.svh"

module bfa_checker
    import bfa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    `BFA_ASSERT_IMPL(a_sat_all_ones, result_valid && result.saturated, result.next_fee == {VALUE_WIDTH{1'b1}}, "saturated beat not clamped")
    `BFA_ASSERT_IMPL(a_flags_exclusive, result_valid, !(result.saturated && result.zero_target), "both flags set")
    `BFA_ASSERT_IMPL(a_stall_source, item_stall, result_valid && result_stall, "input stalled without output backpressure")
    `BFA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "stalled result dropped")
    `BFA_ASSERT_NEXT(a_item_held, item_valid && item_stall, item_valid && $stable(item), "stalled item changed")

endmodule

bind base_fee_adjust_core bfa_checker u_bfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== bench/tb.sv =====
// Testbench for base_fee_adjust_core: queued driver, monitor, fee predictor
`timescale 1ns / 1ps

module tb;
    import bfa_pkg::*;

    localparam int LATENCY   = 132;
    localparam int WDOG_MAX  = 20000;
    localparam logic [63:0] ALL1 = {64{1'b1}};

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    item_t   pending_items[$];
    result_t expected_fees[$];
    int      phase;
    int      hold_cycles;
    int      mismatches;
    int      wdog;
    bit      in_acc;
    bit      hold_go;
    bit      hold_started;

    base_fee_adjust_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic result_t next_base_fee(item_t it);
        result_t     r;
        logic [63:0] target;
        logic [63:0] delta;
        logic [127:0] q;
        logic [127:0] sum;
        begin
            target = it.gas_limit >> 1;
            r.next_fee = it.base_fee;
            r.saturated = 1'b0;
            r.zero_target = 1'b0;
            if (it.gas_used == target)
                r.next_fee = it.base_fee;
            else if (target == 64'd0)
                r.zero_target = 1'b1;
            else if (it.gas_used > target)
            begin
                delta = it.gas_used - target;
                q = ((128'(it.base_fee) * 128'(delta)) / 128'(target)) >> 3;
                if (q == 128'd0)
                    q = 128'd1;
                sum = 128'(it.base_fee) + q;
                if (sum > 128'(ALL1))
                begin
                    r.next_fee = ALL1;
                    r.saturated = 1'b1;
                end
                else
                    r.next_fee = sum[63:0];
            end
            else
            begin
                delta = target - it.gas_used;
                q = ((128'(it.base_fee) * 128'(delta)) / 128'(target)) >> 3;
                if (q >= 128'(it.base_fee))
                    r.next_fee = 64'd1;
                else
                    r.next_fee = it.base_fee - q[63:0];
            end
            return r;
        end
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        int          k;
        begin
            v = {$urandom, $urandom};
            k = $urandom_range(0, 5);
            case (k)
                0: v = v >> $urandom_range(0, 63);
                1: v = 64'($urandom_range(0, 20));
                2: v = ALL1 - 64'($urandom_range(0, 3));
                default: ;
            endcase
            return v;
        end
    endfunction

    task automatic add_item(logic [63:0] fee, logic [63:0] used, logic [63:0] lim);
        item_t it;
        begin
            it.base_fee = fee;
            it.gas_used = used;
            it.gas_limit = lim;
            pending_items.push_back(it);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else if (item_valid && !in_acc)
            ;
        else
        begin
            if (pending_items.size() > 0 &&
                !(phase == 0 && $urandom_range(0, 99) < 10) &&
                !(phase == 1 && $urandom_range(0, 99) < 48))
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        in_acc <= rst_n && item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
            expected_fees.push_back(next_base_fee(item));
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_go && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_cycles <= 399;
            result_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else if (phase == 0)
            result_stall <= ($urandom_range(0, 99) < 48);
        else if (phase == 1)
            result_stall <= ($urandom_range(0, 99) < 10);
        else
            result_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_fees.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", result);
            end
            else if (result !== expected_fees[0])
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("mismatch: exp fee %h sat %b zt %b, got fee %h sat %b zt %b",
                             expected_fees[0].next_fee, expected_fees[0].saturated,
                             expected_fees[0].zero_target, result.next_fee,
                             result.saturated, result.zero_target);
                void'(expected_fees.pop_front());
            end
            else
                void'(expected_fees.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] fee;
        logic [63:0] lim;
        logic [63:0] tgt;
        int          n;
        rst_n = 1'b0;
        phase = 0;
        hold_go = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_item(64'd1000, 64'd50, 64'd100);
        add_item(64'd1000, 64'd0, 64'd0);
        add_item(64'd1000, 64'd5, 64'd1);
        add_item(ALL1, ALL1, 64'd0);
        add_item(ALL1, ALL1, 64'd4);
        add_item(ALL1 - 64'd3, 64'd51, 64'd100);
        add_item(64'd1, 64'd51, 64'd100);
        add_item(64'd0, 64'd51, 64'd100);
        add_item(64'd0, 64'd10, 64'd100);
        add_item(64'd8, 64'd0, 64'd100);
        add_item(64'd100, 64'd0, 64'd100);
        add_item(ALL1, 64'd0, ALL1);
        add_item(ALL1, ALL1, ALL1);
        add_item(ALL1, 64'd0, 64'd2);
        add_item(64'd1000000000, 64'd30000000, 64'd30000000);
        add_item(64'd1000000000, 64'd0, 64'd30000000);
        add_item(ALL1 >> 1, ALL1, 64'd3);
        add_item(64'h8000000000000000, 64'h8000000000000000, 64'h8000000000000001);

        for (int p = 0; p < 3; p++)
        begin
            phase = p;
            n = (p == 0) ? 500 : 550;
            for (int i = 0; i < n; i++)
            begin
                fee = rand64();
                lim = rand64();
                tgt = lim >> 1;
                case ($urandom_range(0, 5))
                    0: add_item(fee, tgt, lim);
                    1: add_item(fee, tgt + 64'($urandom_range(0, 1000)), lim);
                    2: add_item(fee, tgt - 64'($urandom_range(0, 1000)), lim);
                    default: add_item(fee, rand64(), lim);
                endcase
            end
            if (p == 1)
            begin
                @(negedge clk);
                hold_go = 1'b1;
            end
            while (pending_items.size() > 0 || expected_fees.size() > 0)
                @(posedge clk);
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && expected_fees.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/bfa_pkg.sv
design/base_fee_adjust_core.sv
design/bfa_checker.sv
bench/tb.sv
